FILE: design/smsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared widths and types for the sample mean / deviation / pair-max block.
// ----------------------------------------------------------------------------
package smsd_pkg;

  localparam int SAMPLE_W = 10;
  localparam int MEAN_W   = 10;
  localparam int STD_W    = 10;
  localparam int PAIR_W   = 11;
  localparam int COUNT_W  = 9;

  // handed from the accumulator to the finishing sequencer on the last item
  typedef struct packed {
    logic              start;
    logic              overflow;
    logic [PAIR_W-1:0] best_pair;
  } blk_info_t;

endpackage

FILE: design/smsd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsd_in_if / smsd_out_if
// Valid/ready channels for samples in and block statistics out.
// ----------------------------------------------------------------------------
interface smsd_in_if import smsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface smsd_out_if import smsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MEAN_W-1:0]  mean_value;
  logic [STD_W-1:0]   std_dev;
  logic [PAIR_W-1:0]  max_pair_sum;
  logic [COUNT_W-1:0] sample_count;
  logic               overflow;

  modport source (output valid, output mean_value, output std_dev, output max_pair_sum,
                  output sample_count, output overflow, input ready);
  modport sink   (input valid, input mean_value, input std_dev, input max_pair_sum,
                  input sample_count, input overflow, output ready);
endinterface

FILE: design/smsd_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsd_accum
// Per-sample accumulation: count, sum, sum of squares, best adjacent pair.
// ----------------------------------------------------------------------------
module smsd_accum import smsd_pkg::*; #(
  parameter int SW          = 10,
  parameter int CW          = 9,
  parameter int MAX_SAMPLES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  smsd_in_if.sink              in_ch,
  input  logic                 busy,
  output blk_info_t            info,
  output logic [CW-1:0]        n_out,
  output logic [SW+CW-1:0]     sum_out,
  output logic [2*SW+CW-1:0]   sumsq_out
);

  localparam int SUMW = SW + CW;
  localparam int SQW  = 2 * SW + CW;

  logic [CW-1:0]   count_r, count_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [SQW-1:0]  sq_r, sq_nxt;
  logic [SW-1:0]   prev_r, prev_nxt;
  logic [SW:0]     best_r, best_nxt;
  logic            ovf_r, ovf_nxt;

  logic [SW-1:0]   s;
  logic [2*SW-1:0] s_sq;
  logic [SW:0]     pair;
  logic            take;
  logic            accept;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;
  assign s           = in_ch.sample[SW-1:0];
  assign s_sq        = s * s;
  assign pair        = {1'b0, prev_r} + {1'b0, s};
  assign take        = count_r < CW'(MAX_SAMPLES);

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    prev_nxt  = prev_r;
    best_nxt  = best_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (take) begin
        if (count_r != '0 && pair > best_r) begin
          best_nxt = pair;
        end
        sum_nxt   = sum_r + SUMW'(s);
        sq_nxt    = sq_r + SQW'(s_sq);
        prev_nxt  = s;
        count_nxt = count_r + 1'b1;
      end else begin
        // block full, extra samples only raise the flag
        ovf_nxt = 1'b1;
      end
    end
  end

  assign info.start     = accept && in_ch.last;
  assign info.overflow  = ovf_nxt;
  assign info.best_pair = PAIR_W'(best_nxt);
  assign n_out          = count_nxt;
  assign sum_out        = sum_nxt;
  assign sumsq_out      = sq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || info.start) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      prev_r  <= '0;
      best_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      prev_r  <= prev_nxt;
      best_r  <= best_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

FILE: design/smsd_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsd_calc
// End-of-block sequencer: multiply, divide and square root on one adder.
// ----------------------------------------------------------------------------
module smsd_calc import smsd_pkg::*; #(
  parameter int SW = 10,
  parameter int CW = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  blk_info_t            info,
  input  logic [CW-1:0]        n_in,
  input  logic [SW+CW-1:0]     sum_in,
  input  logic [2*SW+CW-1:0]   sumsq_in,
  output logic                 idle,
  smsd_out_if.source           out_ch
);

  localparam int SUMW = SW + CW;
  localparam int WW   = 2 * SW + 2 * CW;
  localparam int AW   = WW + 1;
  localparam int VW   = 2 * SW;
  localparam int CNTW = $clog2(WW);

  typedef enum logic [3:0] {
    S_IDLE, S_MA, S_MB, S_SUB, S_MD, S_DV, S_SQ, S_RND, S_DM, S_DONE
  } state_t;

  state_t            state_r;
  logic [CNTW-1:0]   cnt_r;
  logic [AW-1:0]     acc_r;
  logic [WW-1:0]     mc_r;
  logic [SUMW-1:0]   mp_r;
  logic [WW-1:0]     q_r;
  logic [WW-1:0]     a_r;
  logic [SW-1:0]     root_r;
  logic [CW-1:0]     n_r;
  logic [SUMW-1:0]   sum_r;
  logic [PAIR_W-1:0] pair_r;
  logic              ovf_r;

  logic               out_valid_r;
  logic [MEAN_W-1:0]  out_mean_r;
  logic [STD_W-1:0]   out_std_r;
  logic [PAIR_W-1:0]  out_pair_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_ovf_r;

  // shared add / subtract unit
  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_sub, alu_co;
  logic          last_step;
  logic [WW-1:0] prod;
  logic [WW-1:0] q_shift;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r) inside
      S_MA, S_MB, S_MD: begin
        alu_a = acc_r;
        alu_b = AW'(mc_r);
      end
      S_SUB: begin
        alu_a   = AW'(a_r);
        alu_b   = AW'(q_r);
        alu_sub = 1'b1;
      end
      S_DV, S_DM: begin
        alu_a   = {acc_r[WW-1:0], q_r[WW-1]};
        alu_b   = AW'(mc_r);
        alu_sub = 1'b1;
      end
      S_SQ: begin
        alu_a   = {acc_r[AW-3:0], q_r[VW-1:VW-2]};
        alu_b   = AW'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      S_RND: begin
        alu_a = AW'(q_r);
        alu_b = AW'(mc_r);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign {alu_co, alu_sum} = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                             + (AW + 1)'(alu_sub);

  assign last_step = (cnt_r == '0);
  assign prod      = mp_r[0] ? alu_sum[WW-1:0] : acc_r[WW-1:0];
  assign q_shift   = {q_r[WW-2:0], alu_co};
  assign idle      = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r) inside
        S_IDLE: begin
          if (info.start) begin
            n_r     <= n_in;
            sum_r   <= sum_in;
            pair_r  <= info.best_pair;
            ovf_r   <= info.overflow;
            mc_r    <= WW'(sumsq_in);
            mp_r    <= SUMW'(n_in);
            acc_r   <= '0;
            cnt_r   <= CNTW'(CW - 1);
            state_r <= S_MA;
          end
        end
        S_MA, S_MB, S_MD: begin
          // shift-add multiply, one multiplier bit per cycle
          if (!last_step) begin
            if (mp_r[0]) begin
              acc_r <= alu_sum;
            end
            mc_r  <= mc_r << 1;
            mp_r  <= mp_r >> 1;
            cnt_r <= cnt_r - 1'b1;
          end else if (state_r == S_MA) begin
            a_r     <= prod;
            mc_r    <= WW'(sum_r);
            mp_r    <= sum_r;
            acc_r   <= '0;
            cnt_r   <= CNTW'(SUMW - 1);
            state_r <= S_MB;
          end else if (state_r == S_MB) begin
            q_r     <= prod;
            state_r <= S_SUB;
          end else begin
            mc_r    <= prod;
            acc_r   <= '0;
            cnt_r   <= CNTW'(WW - 1);
            state_r <= S_DV;
          end
        end
        S_SUB: begin
          // n*sumsq - sum^2, clamped at zero
          q_r     <= alu_co ? alu_sum[WW-1:0] : '0;
          mc_r    <= WW'(n_r);
          mp_r    <= SUMW'(n_r);
          acc_r   <= '0;
          cnt_r   <= CNTW'(CW - 1);
          state_r <= S_MD;
        end
        S_DV, S_DM: begin
          // restoring division, one quotient bit per cycle
          if (!last_step) begin
            acc_r <= alu_co ? alu_sum : alu_a;
            q_r   <= q_shift;
            cnt_r <= cnt_r - 1'b1;
          end else if (state_r == S_DV) begin
            q_r     <= WW'(q_shift[VW-1:0]);
            acc_r   <= '0;
            root_r  <= '0;
            cnt_r   <= CNTW'(SW - 1);
            state_r <= S_SQ;
          end else begin
            q_r     <= q_shift;
            state_r <= S_DONE;
          end
        end
        S_SQ: begin
          // square root, one result bit per cycle
          root_r <= {root_r[SW-2:0], alu_co};
          if (!last_step) begin
            acc_r <= alu_co ? alu_sum : alu_a;
            q_r   <= q_r << 2;
            cnt_r <= cnt_r - 1'b1;
          end else begin
            q_r     <= WW'(sum_r);
            mc_r    <= WW'(n_r >> 1);
            state_r <= S_RND;
          end
        end
        S_RND: begin
          // sum + n/2 for round to nearest
          q_r     <= alu_sum[WW-1:0];
          mc_r    <= WW'(n_r);
          acc_r   <= '0;
          cnt_r   <= CNTW'(WW - 1);
          state_r <= S_DM;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_mean_r  <= MEAN_W'(q_r[SW-1:0]);
            out_std_r   <= STD_W'(root_r);
            out_pair_r  <= pair_r;
            out_count_r <= COUNT_W'(n_r);
            out_ovf_r   <= ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mean_value   = out_mean_r;
  assign out_ch.std_dev      = out_std_r;
  assign out_ch.max_pair_sum = out_pair_r;
  assign out_ch.sample_count = out_count_r;
  assign out_ch.overflow     = out_ovf_r;

endmodule

FILE: design/sample_mean_stddev_max_pair_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_mean_stddev_max_pair_core
// Mean, population standard deviation and largest adjacent-pair sum of a
// block of samples closed by a last flag.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the block accumulates. The item with
// last set closes the block; the finishing sequencer then runs its multiplies,
// divisions and square root bit by bit on a single shared adder. Internally
// SW = min(SAMPLE_BITS, 10), CW = clog2(MAX_SAMPLES+1), SUMW = SW+CW and
// WW = 2*SW+2*CW. No sample is taken while the sequencer runs. The result
// sits in an output register, so the next block may start while it waits to
// be taken. Samples beyond MAX_SAMPLES in a block are dropped and flagged.
module sample_mean_stddev_max_pair_core import smsd_pkg::*; #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  smsd_in_if.sink     in_ch,
  smsd_out_if.source  out_ch
);

  localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  blk_info_t              info;
  logic [CW-1:0]          n_blk;
  logic [SW+CW-1:0]       sum_blk;
  logic [2*SW+CW-1:0]     sumsq_blk;
  logic                   calc_idle;

  smsd_accum #(
    .SW          (SW),
    .CW          (CW),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .busy      (!calc_idle),
    .info      (info),
    .n_out     (n_blk),
    .sum_out   (sum_blk),
    .sumsq_out (sumsq_blk)
  );

  smsd_calc #(
    .SW (SW),
    .CW (CW)
  ) u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .info     (info),
    .n_in     (n_blk),
    .sum_in   (sum_blk),
    .sumsq_in (sumsq_blk),
    .idle     (calc_idle),
    .out_ch   (out_ch)
  );

  // closing item hands over to the sequencer, which blocks further samples
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.last |=> !in_ch.ready)
    else $error("sample taken right after a closing item");

  a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> int'(out_ch.max_pair_sum) <= 2 * ((1 << SW) - 1))
    else $error("pair sum out of range");

  a_single_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (MAX_SAMPLES < 512) && out_ch.sample_count == COUNT_W'(1)
    |-> out_ch.max_pair_sum == '0 && out_ch.std_dev == '0)
    else $error("single-sample block with nonzero pair or deviation");

endmodule
